FILE: rtl/core/tcpu_pkg.sv
// Shared types and constants for the teaching cpu execute unit.
`default_nettype none
package tcpu_pkg;
  localparam int unsigned MemAddrBitsDef = 16;
  localparam logic [31:0] StartReset = 32'h4000_0000;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EXEC = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [3:0] OP_HALT = 4'd0;
  localparam logic [3:0] OP_INT  = 4'd1;
  localparam logic [3:0] OP_CALL = 4'd2;
  localparam logic [3:0] OP_JMP  = 4'd3;
  localparam logic [3:0] OP_XCHG = 4'd4;
  localparam logic [3:0] OP_ARIT = 4'd5;
  localparam logic [3:0] OP_LOGI = 4'd6;
  localparam logic [3:0] OP_SHFT = 4'd7;
  localparam logic [3:0] OP_ST   = 4'd8;
  localparam logic [3:0] OP_LD   = 4'd9;

  localparam logic [3:0] SP_IDX = 4'd14;
  localparam logic [3:0] PC_IDX = 4'd15;

  // divider control
  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic [31:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/teaching_cpu_execute_unit.sv
// Top level of the teaching cpu execute unit: sequencer, register file, datapath.
//
// Usage:
//  - Input channel in_*: one word per request. req_type 0 stores load_data
//    little-endian at load_address, 1 executes the instruction at r15, 2 reads
//    register read_index (0-15 gprs, 16 status, 17 handler, 18 cause).
//  - Result channel out_*: one word per request with read_value, next_pc,
//    halted and fault. The result sits in an output register; out_stall
//    holds it, and the next request waits until it has been taken.
//  - cfg_*: writes start_address, which also loads r15. Write only when idle.
//  - A load writes one byte per cycle. An execute fetches its word byte by
//    byte, then does register work, reads and writes memory byte by byte
//    through the single byte port, or runs a divide in the restoring divider.
//    No overlap: the next request is taken in the cycle after the result leaves.
//  - Reset: registers clear, r15 = 0x40000000, then a clearing sweep zeroes all
//    2^MEM_ADDR_BITS bytes of main memory; in_stall stays high meanwhile.
//  - Unaligned words and address wrap are handled byte by byte.
`default_nettype none
module teaching_cpu_execute_unit
  import tcpu_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = MemAddrBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_start_address,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_load_address,
  input  wire logic [31:0] in_load_data,
  input  wire logic [4:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_value,
  output logic [31:0]      out_next_pc,
  output logic             out_halted,
  output logic             out_fault
);
  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_RD1, S_RD2, S_WR, S_DIV, S_DONE
  } state_t;

  // what happens after a word read completes
  typedef enum logic [3:0] {
    N_EXEC, N_CALLM, N_JMPM, N_ST2, N_LDRA, N_LD3, N_POPA, N_CSR6, N_CSR7, N_NONE
  } nxt_t;

  state_t      state_r;
  nxt_t        rnext_r;
  logic [31:0] regs_r [16];
  logic [31:0] status_r, handler_r, cause_r;
  logic        halted_r, fault_r;
  logic [31:0] ir_r;
  logic [31:0] addr_r;      // word base address
  logic [31:0] wbuf_r;      // word being assembled / stored
  logic [1:0]  byte_r;
  logic        rd_wait_r;
  logic        push2_r;     // int: second push pending
  logic [31:0] read_value_r;

  logic        mem_we;
  logic [31:0] mem_abyte;
  logic [7:0]  mem_rdata;
  logic        clearing;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tcpu_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .addr    (mem_abyte[MEM_ADDR_BITS-1:0]),
    .wdata   (wbuf_r[8*byte_r +: 8]),
    .rdata   (mem_rdata),
    .clearing(clearing)
  );

  tcpu_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // instruction fields
  logic [3:0]  op, md, ra, rb, rc;
  logic [31:0] disp, va, vb, vc, sp_dec;
  assign op     = ir_r[31:28];
  assign md     = ir_r[27:24];
  assign ra     = ir_r[23:20];
  assign rb     = ir_r[19:16];
  assign rc     = ir_r[15:12];
  assign disp   = {{20{ir_r[11]}}, ir_r[11:0]};
  assign va     = regs_r[ra];
  assign vb     = regs_r[rb];
  assign vc     = regs_r[rc];
  assign sp_dec = regs_r[SP_IDX] - 32'd4;

  assign mem_abyte = addr_r + {30'd0, byte_r};
  assign mem_we    = (state_r == S_WR) && !clearing;

  function automatic logic [31:0] csr_rd(input logic [3:0] n, input logic [31:0] s,
                                         input logic [31:0] h, input logic [31:0] c);
    logic [31:0] v;
    v = (n == 4'd0) ? s : (n == 4'd1) ? h : c;
    return v;
  endfunction

  assign cfg_ready = (state_r == S_IDLE) && !out_valid;
  assign in_stall  = (state_r != S_IDLE) || out_valid || clearing || cfg_valid;

  always_comb begin
    div_req.start    = (state_r == S_DECODE) && (op == OP_ARIT) && (md == 4'd3)
                       && (vb != 32'd0);
    div_req.dividend = vc;
    div_req.divisor  = vb;
  end

  logic [31:0] mulp;
  assign mulp = vc * vb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      halted_r  <= 1'b0;
      fault_r   <= 1'b0;
      status_r  <= '0;
      handler_r <= '0;
      cause_r   <= '0;
      push2_r   <= 1'b0;
      rd_wait_r <= 1'b0;
      byte_r    <= '0;
      rnext_r   <= N_NONE;
      for (int i = 0; i < 15; i++) regs_r[i] <= '0;
      regs_r[PC_IDX] <= StartReset;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            regs_r[PC_IDX] <= cfg_start_address;
          end else if (in_valid && !in_stall) begin
            byte_r       <= '0;
            priority if (in_req_type == REQ_LOAD) begin
              read_value_r <= '0;
              addr_r  <= in_load_address;
              wbuf_r  <= in_load_data;
              rnext_r <= N_NONE;
              state_r <= S_WR;
            end else if (in_req_type == REQ_EXEC && !halted_r && !fault_r) begin
              read_value_r <= '0;
              addr_r    <= regs_r[PC_IDX];
              rnext_r   <= N_EXEC;
              rd_wait_r <= 1'b0;
              state_r   <= S_RD1;
            end else begin
              // 16, 17 and 18 map onto csr 0, 1 and 2 through the low bits
              if (in_req_type == REQ_READ && in_read_index < 5'd16)
                read_value_r <= regs_r[in_read_index[3:0]];
              else if (in_req_type == REQ_READ && in_read_index <= 5'd18)
                read_value_r <= csr_rd({2'b0, in_read_index[1:0]},
                                       status_r, handler_r, cause_r);
              else
                read_value_r <= '0;
              state_r <= S_DONE;
            end
          end
        end
        // byte-serial read: address out, data back next cycle
        S_RD1: begin
          rd_wait_r <= !rd_wait_r;
          if (rd_wait_r) begin
            wbuf_r[8*byte_r +: 8] <= mem_rdata;
            byte_r    <= byte_r + 2'd1;
            if (byte_r == 2'd3) state_r <= S_RD2;
          end
        end
        S_RD2: begin
          byte_r  <= '0;
          state_r <= S_DONE;
          unique case (rnext_r)
            N_EXEC: begin
              ir_r <= wbuf_r;
              regs_r[PC_IDX] <= regs_r[PC_IDX] + 32'd4;
              state_r <= S_DECODE;
            end
            N_CALLM, N_JMPM: regs_r[PC_IDX] <= wbuf_r;
            N_ST2: begin
              addr_r  <= wbuf_r;
              wbuf_r  <= vc;
              state_r <= S_WR;
            end
            N_LDRA: regs_r[ra] <= wbuf_r;
            N_LD3: begin
              // same register on both sides: the base update lands on the loaded word
              if (ra == rb) regs_r[rb] <= wbuf_r + disp;
              else begin
                regs_r[rb] <= vb + disp;
                regs_r[ra] <= wbuf_r;
              end
            end
            N_POPA: begin
              if (ra == SP_IDX) regs_r[SP_IDX] <= wbuf_r + 32'd4;
              else begin
                regs_r[SP_IDX] <= regs_r[SP_IDX] + 32'd4;
                regs_r[ra] <= wbuf_r;
              end
            end
            N_CSR6, N_CSR7: begin
              if (rnext_r == N_CSR7) regs_r[SP_IDX] <= regs_r[SP_IDX] + 32'd4;
              if (ra == 4'd0) status_r <= wbuf_r;
              else if (ra == 4'd1) handler_r <= wbuf_r;
              else cause_r <= wbuf_r;
            end
            default: ;
          endcase
        end
        S_WR: begin
          if (!clearing) begin
            byte_r <= byte_r + 2'd1;
            if (byte_r == 2'd3) begin
              if (push2_r) begin
                // int: second push of the return pc, then vector
                push2_r        <= 1'b0;
                addr_r         <= sp_dec;
                regs_r[SP_IDX] <= sp_dec;
                wbuf_r         <= regs_r[PC_IDX];
                regs_r[PC_IDX] <= handler_r;
                cause_r        <= 32'd4;
                status_r       <= status_r & ~32'h1;
              end else if (rnext_r == N_CALLM || rnext_r == N_EXEC) begin
                addr_r    <= (rnext_r == N_CALLM) ? va + vb + disp : addr_r;
                rd_wait_r <= 1'b0;
                state_r   <= (rnext_r == N_CALLM) ? S_RD1 : S_DONE;
                if (rnext_r == N_EXEC) begin
                  regs_r[PC_IDX] <= va + vb + disp;
                  rnext_r <= N_NONE;
                end
              end else begin
                state_r <= S_DONE;
              end
            end
          end
        end
        S_DECODE: begin
          rd_wait_r <= 1'b0;
          byte_r    <= '0;
          state_r   <= S_DONE;
          rnext_r   <= N_NONE;
          unique case (op)
            OP_HALT: if (ir_r != 32'd0) fault_r <= 1'b1; else halted_r <= 1'b1;
            OP_INT: begin
              regs_r[SP_IDX] <= sp_dec;
              addr_r  <= sp_dec;
              wbuf_r  <= status_r;
              push2_r <= 1'b1;
              state_r <= S_WR;
            end
            OP_CALL: begin
              if (md > 4'd1) fault_r <= 1'b1;
              else begin
                regs_r[SP_IDX] <= sp_dec;
                addr_r  <= sp_dec;
                wbuf_r  <= regs_r[PC_IDX];
                // N_EXEC marks the direct target after the push
                rnext_r <= (md == 4'd0) ? N_EXEC : N_CALLM;
                state_r <= S_WR;
              end
            end
            OP_JMP: begin
              if (md[2]) fault_r <= 1'b1;
              else if ((md[1:0] == 2'd0) || (md[1:0] == 2'd1 && vb == vc) ||
                       (md[1:0] == 2'd2 && vb != vc) ||
                       (md[1:0] == 2'd3 && vb > vc)) begin
                if (md[3]) begin
                  addr_r  <= va + disp;
                  rnext_r <= N_JMPM;
                  state_r <= S_RD1;
                end else regs_r[PC_IDX] <= va + disp;
              end
            end
            OP_XCHG: begin
              if (rb != rc) begin
                regs_r[rb] <= vc;
                regs_r[rc] <= vb;
              end
            end
            OP_ARIT: begin
              unique case (md)
                4'd0: regs_r[ra] <= vb + vc;
                4'd1: regs_r[ra] <= vc - vb;
                4'd2: regs_r[ra] <= mulp;
                4'd3: if (vb == 32'd0) regs_r[ra] <= '1; else state_r <= S_DIV;
                default: fault_r <= 1'b1;
              endcase
            end
            OP_LOGI: begin
              unique case (md)
                4'd0: regs_r[ra] <= ~vb;
                4'd1: regs_r[ra] <= vb & vc;
                4'd2: regs_r[ra] <= vb | vc;
                4'd3: regs_r[ra] <= vb ^ vc;
                default: fault_r <= 1'b1;
              endcase
            end
            OP_SHFT: begin
              if (md > 4'd1) fault_r <= 1'b1;
              else if (vc >= 32'd32) regs_r[ra] <= '0;
              else if (md == 4'd0) regs_r[ra] <= vb << vc[4:0];
              else regs_r[ra] <= vb >> vc[4:0];
            end
            OP_ST: begin
              unique case (md)
                4'd0: begin
                  addr_r <= va + vb + disp;
                  wbuf_r <= vc;
                  state_r <= S_WR;
                end
                4'd1: begin
                  regs_r[SP_IDX] <= sp_dec;
                  addr_r  <= sp_dec;
                  wbuf_r  <= (rc == SP_IDX) ? sp_dec : vc;
                  state_r <= S_WR;
                end
                4'd2: begin
                  addr_r  <= va + vb + disp;
                  rnext_r <= N_ST2;
                  state_r <= S_RD1;
                end
                default: fault_r <= 1'b1;
              endcase
            end
            OP_LD: begin
              unique case (md)
                4'd0: if (rb > 4'd2) fault_r <= 1'b1;
                      else regs_r[ra] <= csr_rd(rb, status_r, handler_r, cause_r);
                4'd1: regs_r[ra] <= vb + disp;
                4'd2: begin
                  addr_r <= vb + vc + disp; rnext_r <= N_LDRA; state_r <= S_RD1;
                end
                4'd3: begin
                  if (disp == 32'd4) begin
                    addr_r <= regs_r[SP_IDX]; rnext_r <= N_POPA;
                  end else begin
                    addr_r <= vb; rnext_r <= N_LD3;
                  end
                  state_r <= S_RD1;
                end
                4'd4: if (ra > 4'd2) fault_r <= 1'b1;
                      else if (ra == 4'd0) status_r <= vb;
                      else if (ra == 4'd1) handler_r <= vb;
                      else cause_r <= vb;
                4'd5: if (ra > 4'd2 || rb > 4'd2) fault_r <= 1'b1;
                      else if (ra == 4'd0)
                        status_r <= csr_rd(rb, status_r, handler_r, cause_r) + disp;
                      else if (ra == 4'd1)
                        handler_r <= csr_rd(rb, status_r, handler_r, cause_r) + disp;
                      else cause_r <= csr_rd(rb, status_r, handler_r, cause_r) + disp;
                4'd6: if (ra > 4'd2) fault_r <= 1'b1;
                      else begin
                        addr_r <= vb + vc + disp; rnext_r <= N_CSR6; state_r <= S_RD1;
                      end
                4'd7: if (ra > 4'd2) fault_r <= 1'b1;
                      else begin
                        addr_r <= regs_r[SP_IDX]; rnext_r <= N_CSR7; state_r <= S_RD1;
                      end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_rsp.done) begin
            regs_r[ra] <= div_rsp.quotient;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_read_value = read_value_r;
  assign out_next_pc    = regs_r[PC_IDX];
  assign out_halted     = halted_r;
  assign out_fault      = fault_r;
endmodule
`default_nettype wire

FILE: rtl/core/tcpu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tcpu_div
  import tcpu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;

  always_comb begin
    trial   = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    quo_nxt = {quo_r[30:0], ~trial[32]};
    rem_nxt = trial[32] ? {rem_r[30:0], quo_r[31]} : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

FILE: rtl/core/tcpu_mem.sv
// Byte-wide main memory with a clearing sweep after reset.
`default_nettype none
module tcpu_mem
  import tcpu_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = MemAddrBitsDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     we,
  input  wire logic [MEM_ADDR_BITS-1:0] addr,
  input  wire logic [7:0]               wdata,
  output logic [7:0]                    rdata,
  output logic                          clearing
);
  localparam int unsigned Depth = 1 << MEM_ADDR_BITS;
  logic [7:0] mem [Depth];
  logic [MEM_ADDR_BITS-1:0] clr_r;
  logic clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (&clr_r) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= 8'h00;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  assign clearing = clearing_r;
endmodule
`default_nettype wire

FILE: rtl/core/tcpu_checker.sv
// Port-level checker for the teaching cpu execute unit, bound to the top level.
`default_nettype none
module tcpu_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_halted,
  input wire logic out_fault,
  input wire logic [31:0] out_next_pc
);
  // a new word is never taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(in_valid && !in_stall)) else $error("input taken while result pending");
  // sticky halt
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |=> out_halted) else $error("halt cleared");
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |=> out_fault) else $error("fault cleared");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_pc))
    else $error("stalled result changed");
endmodule

bind teaching_cpu_execute_unit tcpu_checker u_tcpu_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_halted(out_halted),
  .out_fault(out_fault), .out_next_pc(out_next_pc)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the teaching cpu execute unit: directed table, then random programs.
`timescale 1ns / 1ps
module tb
  import tcpu_pkg::*;
();

  // Request code the block ignores; it still answers with its state.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned MEM_BYTES = 1 << MemAddrBitsDef;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned RAND_ITEMS = 240;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_start_address = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [31:0] in_load_address = '0;
  logic [31:0] in_load_data = '0;
  logic [4:0] in_read_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_read_value;
  logic [31:0] out_next_pc;
  logic out_halted;
  logic out_fault;

  teaching_cpu_execute_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_start_address(cfg_start_address),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_load_address(in_load_address), .in_load_data(in_load_data),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_read_value(out_read_value),
    .out_next_pc(out_next_pc), .out_halted(out_halted), .out_fault(out_fault)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] read_value;
    logic [31:0] next_pc;
    logic        halted;
    logic        fault;
  } cpu_word_t;

  // Shadow copy of the core: memory, registers, csrs and run state.
  logic [7:0]  shadow_mem [MEM_BYTES];
  logic [31:0] shadow_gpr [16];
  logic [31:0] shadow_status, shadow_handler, shadow_cause;
  logic        shadow_halted, shadow_fault;

  cpu_word_t pending_words [$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;

  function automatic logic [31:0] mem_word(logic [31:0] addr);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < 4; i++)
      v[8*i +: 8] = shadow_mem[(addr + i) % MEM_BYTES];
    return v;
  endfunction

  task automatic put_word(logic [31:0] addr, logic [31:0] v);
    for (int i = 0; i < 4; i++)
      shadow_mem[(addr + i) % MEM_BYTES] = v[8*i +: 8];
  endtask

  function automatic logic [31:0] csr_value(logic [3:0] n);
    if (n == 0) return shadow_status;
    if (n == 1) return shadow_handler;
    return shadow_cause;
  endfunction

  task automatic set_csr(logic [3:0] n, logic [31:0] v);
    if (n == 0) shadow_status = v;
    else if (n == 1) shadow_handler = v;
    else shadow_cause = v;
  endtask

  task automatic push_reg(logic [3:0] r);
    // drop the stack pointer first; the source is read after the decrement
    shadow_gpr[SP_IDX] = shadow_gpr[SP_IDX] - 4;
    put_word(shadow_gpr[SP_IDX], shadow_gpr[r]);
  endtask

  task automatic run_instruction();
    logic [31:0] w, d, t;
    logic [3:0] op, md, a, b, c;
    logic bad, take;
    w = mem_word(shadow_gpr[PC_IDX]);
    op = w[31:28]; md = w[27:24]; a = w[23:20]; b = w[19:16]; c = w[15:12];
    d = {{20{w[11]}}, w[11:0]};
    bad = 1'b0;
    shadow_gpr[PC_IDX] = shadow_gpr[PC_IDX] + 4;
    case (op)
      OP_HALT: begin
        if (w != 0) bad = 1'b1;
        else shadow_halted = 1'b1;
      end
      OP_INT: begin
        shadow_gpr[SP_IDX] = shadow_gpr[SP_IDX] - 4;
        put_word(shadow_gpr[SP_IDX], shadow_status);
        push_reg(PC_IDX);
        shadow_cause = 32'd4;
        shadow_status[0] = 1'b0;
        shadow_gpr[PC_IDX] = shadow_handler;
      end
      OP_CALL: begin
        if (md > 1) bad = 1'b1;
        else begin
          push_reg(PC_IDX);
          t = shadow_gpr[a] + shadow_gpr[b] + d;
          shadow_gpr[PC_IDX] = (md == 0) ? t : mem_word(t);
        end
      end
      OP_JMP: begin
        if (md[2]) bad = 1'b1;
        else begin
          case (md[1:0])
            2'd0: take = 1'b1;
            2'd1: take = shadow_gpr[b] == shadow_gpr[c];
            2'd2: take = shadow_gpr[b] != shadow_gpr[c];
            default: take = shadow_gpr[b] > shadow_gpr[c];
          endcase
          if (take)
            shadow_gpr[PC_IDX] = md[3] ? mem_word(shadow_gpr[a] + d) : shadow_gpr[a] + d;
        end
      end
      OP_XCHG: begin
        t = shadow_gpr[b];
        shadow_gpr[b] = shadow_gpr[c];
        shadow_gpr[c] = t;
      end
      OP_ARIT: begin
        case (md)
          4'd0: shadow_gpr[a] = shadow_gpr[b] + shadow_gpr[c];
          4'd1: shadow_gpr[a] = shadow_gpr[c] - shadow_gpr[b];
          4'd2: shadow_gpr[a] = shadow_gpr[c] * shadow_gpr[b];
          4'd3: shadow_gpr[a] = (shadow_gpr[b] == 0) ? 32'hffff_ffff
                                                     : shadow_gpr[c] / shadow_gpr[b];
          default: bad = 1'b1;
        endcase
      end
      OP_LOGI: begin
        case (md)
          4'd0: shadow_gpr[a] = ~shadow_gpr[b];
          4'd1: shadow_gpr[a] = shadow_gpr[b] & shadow_gpr[c];
          4'd2: shadow_gpr[a] = shadow_gpr[b] | shadow_gpr[c];
          4'd3: shadow_gpr[a] = shadow_gpr[b] ^ shadow_gpr[c];
          default: bad = 1'b1;
        endcase
      end
      OP_SHFT: begin
        t = shadow_gpr[c];
        if (md == 0) shadow_gpr[a] = (t >= 32) ? '0 : shadow_gpr[b] << t[4:0];
        else if (md == 1) shadow_gpr[a] = (t >= 32) ? '0 : shadow_gpr[b] >> t[4:0];
        else bad = 1'b1;
      end
      OP_ST: begin
        t = shadow_gpr[a] + shadow_gpr[b] + d;
        if (md == 0) put_word(t, shadow_gpr[c]);
        else if (md == 1) push_reg(c);
        else if (md == 2) put_word(mem_word(t), shadow_gpr[c]);
        else bad = 1'b1;
      end
      OP_LD: begin
        case (md)
          4'd0: if (b > 2) bad = 1'b1; else shadow_gpr[a] = csr_value(b);
          4'd1: shadow_gpr[a] = shadow_gpr[b] + d;
          4'd2: shadow_gpr[a] = mem_word(shadow_gpr[b] + shadow_gpr[c] + d);
          4'd3: begin
            if (d != 4) begin
              shadow_gpr[a] = mem_word(shadow_gpr[b]);
              shadow_gpr[b] = shadow_gpr[b] + d;
            end else begin
              shadow_gpr[a] = mem_word(shadow_gpr[SP_IDX]);
              shadow_gpr[SP_IDX] = shadow_gpr[SP_IDX] + 4;
            end
          end
          4'd4: if (a > 2) bad = 1'b1; else set_csr(a, shadow_gpr[b]);
          4'd5: if (a > 2 || b > 2) bad = 1'b1; else set_csr(a, csr_value(b) + d);
          4'd6: if (a > 2) bad = 1'b1;
                else set_csr(a, mem_word(shadow_gpr[b] + shadow_gpr[c] + d));
          4'd7: begin
            if (a > 2) bad = 1'b1;
            else begin
              set_csr(a, mem_word(shadow_gpr[SP_IDX]));
              shadow_gpr[SP_IDX] = shadow_gpr[SP_IDX] + 4;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (bad) shadow_fault = 1'b1;
  endtask

  task automatic predict_cpu_word(logic [1:0] req, logic [31:0] addr, logic [31:0] data,
                                  logic [4:0] idx, output cpu_word_t w);
    w = '0;
    if (req == REQ_LOAD) put_word(addr, data);
    else if (req == REQ_EXEC) begin
      if (!shadow_halted && !shadow_fault) run_instruction();
    end else if (req == REQ_READ) begin
      if (idx < 16) w.read_value = shadow_gpr[idx[3:0]];
      else if (idx <= 18) w.read_value = csr_value(4'(idx - 5'd16));
    end
    w.next_pc = shadow_gpr[PC_IDX];
    w.halted = shadow_halted;
    w.fault = shadow_fault;
  endtask

  // Present one request word; predict it once accepted. A row with a typed-in
  // read value overrides the predicted one.
  task automatic send_request(logic [1:0] req, logic [31:0] addr, logic [31:0] data,
                              logic [4:0] idx, bit typed = 0, logic [31:0] typed_rv = '0);
    cpu_word_t w;
    if ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_gap_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_load_address <= addr;
    in_load_data <= data;
    in_read_index <= idx;
    do @(posedge clk); while (in_stall);
    predict_cpu_word(req, addr, data, idx, w);
    if (typed) w.read_value = typed_rv;
    pending_words.push_back(w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_start_address(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_start_address <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_gpr[PC_IDX] = v;
  endtask

  // Random instruction that never stops the core.
  function automatic logic [31:0] random_instruction();
    logic [3:0] op, md, a, b, c;
    int pick;
    pick = $urandom_range(0, 19);
    a = 4'($urandom); b = 4'($urandom); c = 4'($urandom);
    md = 4'd0;
    if (pick == 0) op = OP_INT;
    else if (pick <= 2) begin op = OP_CALL; md = 4'($urandom_range(0, 1)); end
    else if (pick <= 5) begin
      op = OP_JMP; md = 4'($urandom_range(0, 1) * 8 + $urandom_range(0, 3));
    end
    else if (pick == 6) op = OP_XCHG;
    else if (pick <= 9) begin op = OP_ARIT; md = 4'($urandom_range(0, 3)); end
    else if (pick <= 11) begin op = OP_LOGI; md = 4'($urandom_range(0, 3)); end
    else if (pick <= 13) begin op = OP_SHFT; md = 4'($urandom_range(0, 1)); end
    else if (pick <= 15) begin op = OP_ST; md = 4'($urandom_range(0, 2)); end
    else if (pick <= 18) begin
      op = OP_LD; md = 4'($urandom_range(0, 15));
      if (md == 0) b = 4'($urandom_range(0, 2));
      if (md >= 4 && md <= 7) a = 4'($urandom_range(0, 2));
      if (md == 5) b = 4'($urandom_range(0, 2));
    end
    else begin op = 4'($urandom_range(10, 15)); md = 4'($urandom); end
    return {op, md, a, b, c, 12'($urandom)};
  endfunction

  task automatic random_phase(int gap_pct, int stall_pct);
    int dice;
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      dice = $urandom_range(99);
      if (dice < 10) send_request(REQ_READ, $urandom, $urandom, 5'($urandom));
      else if (dice < 16) send_request(REQ_LOAD, $urandom, $urandom, 5'($urandom));
      else if (dice < 18) send_request(REQ_NONE, $urandom, $urandom, 5'($urandom));
      else begin
        // well-formed: place an instruction at the pc, then run it
        send_request(REQ_LOAD, shadow_gpr[PC_IDX], random_instruction(), 5'($urandom));
        send_request(REQ_EXEC, $urandom, $urandom, 5'($urandom));
        n++;
      end
    end
  endtask

  typedef struct {
    logic [1:0]  req;
    logic [31:0] addr;
    logic [31:0] data;
    logic [4:0]  idx;
    bit          at_pc;
    bit          typed;
    logic [31:0] rv;
  } table_row_t;

  // at_pc rows store the word at the current pc instead of addr.
  table_row_t directed_rows [] = '{
    '{REQ_READ, 0, 0, 15, 0, 1, StartReset},
    '{REQ_READ, 0, 0, 31, 0, 1, 32'h0},
    '{REQ_READ, 0, 0, 18, 0, 1, 32'h0},
    '{REQ_NONE, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h9110_0fff, 0, 1, 0, 0},  // r1 = r1 - 1
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h7031_1000, 0, 1, 0, 0},  // r3 = r1 << r1, count too large
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h5340_1000, 0, 1, 0, 0},  // r4 = r1 / r0
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_READ, 0, 0, 4, 0, 1, 32'hffff_ffff},
    '{REQ_READ, 0, 0, 3, 0, 1, 32'h0},
    '{REQ_LOAD, 0, 32'h8100_1000, 0, 1, 0, 0},  // push r1
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h9411_0000, 0, 1, 0, 0},  // handler = r1
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h1000_0000, 0, 1, 0, 0},  // int, pc lands on the wrap edge
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_READ, 0, 0, 18, 0, 1, 32'h4},
    '{REQ_LOAD, 0, 32'h3000_0040, 0, 1, 0, 0},  // jmp r0 + 0x40, unaligned fetch
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 0, 32'h9330_0004, 0, 1, 0, 0},  // pop r3
    '{REQ_EXEC, 0, 0, 0, 0, 0, 0},
    '{REQ_LOAD, 32'hffff_fffe, 32'hffff_ffff, 0, 0, 0, 0}
  };

  // Take results and stall the result side at random.
  always @(posedge clk) begin
    cpu_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_read_value !== want.read_value) begin
          $error("read_value expected %h got %h", want.read_value, out_read_value);
          errors++;
        end
        if (out_next_pc !== want.next_pc) begin
          $error("next_pc expected %h got %h", want.next_pc, out_next_pc);
          errors++;
        end
        if (out_halted !== want.halted) begin
          $error("halted expected %b got %b", want.halted, out_halted);
          errors++;
        end
        if (out_fault !== want.fault) begin
          $error("fault expected %b got %b", want.fault, out_fault);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    table_row_t row;
    for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = '0;
    for (int i = 0; i < 16; i++) shadow_gpr[i] = '0;
    shadow_gpr[PC_IDX] = StartReset;
    shadow_status = '0; shadow_handler = '0; shadow_cause = '0;
    shadow_halted = 1'b0; shadow_fault = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, sender idles lightly and the receiver heavily
    sender_gap_pct = 13;
    receiver_stall_pct = 74;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.req, row.at_pc ? shadow_gpr[PC_IDX] : row.addr, row.data, row.idx,
                   row.typed, row.rv);
    end

    // hold off until the block is idle, then move the start address between phases
    drain_results();
    write_start_address(32'h0);
    random_phase(13, 74);
    drain_results();
    write_start_address(32'hffff_ffff);
    random_phase(74, 13);
    drain_results();
    write_start_address($urandom);
    random_phase(0, 0);

    // stop the core: either an undefined encoding or a valid halt, then poke it
    send_request(REQ_LOAD, shadow_gpr[PC_IDX],
                 ($urandom_range(1) != 0) ? 32'h5400_0000 : 32'h0, 0);
    send_request(REQ_EXEC, 0, 0, 0);
    send_request(REQ_LOAD, shadow_gpr[PC_IDX], 32'h9110_0001, 0);
    send_request(REQ_EXEC, 0, 0, 0);
    send_request(REQ_READ, 0, 0, 1);

    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
